### rtl/core/hbs_pkg.sv
// Shared types and constants for the hierarchical bitset successor block.
// Holds operation codes, sequencer states and the bit-scan request/response types.
// No dependencies.
`default_nettype none

package hbs_pkg;

    localparam int WORD_BITS  = 64;
    localparam int IDX_W      = 6;
    localparam int POS_W      = 12;
    localparam int IN_POS_W   = 13;
    localparam int OP_W       = 3;
    localparam int LEAF_WORDS = 64;
    localparam int CAPACITY   = 4096;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [IDX_W-1:0]     t_idx;

    // request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TEST   = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_SUCC   = 3'd3,
        OP_PRED   = 3'd4
    } t_op;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAF,
        ST_SCAN_LEAF,
        ST_SCAN_SUM,
        ST_LEAF2,
        ST_SCAN_DESC,
        ST_DONE
    } t_state;

    // scan direction: lowest set bit at or above bound, or highest at or below
    typedef enum logic {
        SCAN_LOW,
        SCAN_HIGH
    } t_scan_dir;

    typedef struct packed {
        t_word     word;
        t_idx      bound;
        t_scan_dir dir;
    } t_scan_req;

    typedef struct packed {
        logic any_set;
        t_idx idx;
    } t_scan_rsp;

endpackage

`default_nettype wire

### rtl/core/hbs_scan.sv
// Shared bit-scan unit: masks a 64-bit word against a bound and finds the
// lowest or highest remaining set bit, result registered. Uses hbs_pkg.
`default_nettype none

module hbs_scan
    import hbs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_scan_req i_req,
    output t_scan_rsp      o_rsp
);

    t_word     masked;
    t_word     src;
    t_word     iso;
    t_idx      enc;
    t_scan_rsp r_rsp;
    t_scan_rsp n_rsp;

    // mask, bit-reverse for the high direction, isolate lowest one, encode
    always_comb begin
        if (i_req.dir == SCAN_LOW) begin
            masked = i_req.word & ({WORD_BITS{1'b1}} << i_req.bound);
        end else begin
            masked = i_req.word & ({WORD_BITS{1'b1}} >> (~i_req.bound));
        end
        for (int k = 0; k < WORD_BITS; k++) begin
            src[k] = (i_req.dir == SCAN_LOW) ? masked[k] : masked[WORD_BITS-1-k];
        end
        iso = src & (~src + t_word'(1));
        enc = '0;
        for (int k = 0; k < WORD_BITS; k++) begin
            if (iso[k]) begin
                enc = enc | IDX_W'(k);
            end
        end
        n_rsp.any_set = |masked;
        n_rsp.idx     = (i_req.dir == SCAN_LOW) ? enc : ~enc;
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

### rtl/core/hierarchical_bitset_successor.sv
// Hierarchical bitset over 4096 positions with a leaf word memory, a summary
// register and a sequencer around the shared scan unit. Uses hbs_pkg, hbs_scan.
//
// Usage: one request item on the input channel (i_valid / o_stall) carries an
// operation and a position; exactly one result item (found, result_position)
// leaves on the output channel (o_valid / i_stall).
// Test, insert and remove read the leaf word, then finish. Successor and
// predecessor also scan the first leaf word and finish on a hit or with no
// word left to search; else they scan the summary, finish on a miss, and
// otherwise read and scan the leaf word it names. Each step waits on the
// registered leaf memory read or the registered output of the one bit-scan unit.
// o_stall is high from acceptance until the result moves into the output
// register, so one item is in work at a time; a new item is taken while a
// finished result still waits in the output register.
// If the receiver stalls, the output register holds; a finished result
// then waits in the sequencer until the register frees.
// Reset (synchronous, active low) empties the set at once: per-word valid
// bits and the summary word clear, no clearing pass is needed.
`default_nettype none

module hierarchical_bitset_successor
    import hbs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [OP_W-1:0]     i_operation,
    input  wire logic [IN_POS_W-1:0] i_position,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_found,
    output logic [POS_W-1:0]         o_result_position
);

    t_state r_state, n_state;
    logic [OP_W-1:0] r_op, n_op;
    t_idx   r_widx, n_widx;
    t_idx   r_bpos, n_bpos;
    logic   r_skip, n_skip;
    logic   r_res_found, n_res_found;
    logic [POS_W-1:0] r_res_pos, n_res_pos;
    t_word  r_summary, n_summary;
    logic   r_o_valid, n_o_valid;
    logic   r_o_found, n_o_found;
    logic [POS_W-1:0] r_o_pos, n_o_pos;

    // leaf word memory with per-word valid bits
    t_word  r_mem [LEAF_WORDS];
    logic [LEAF_WORDS-1:0] r_vld;
    t_word  r_rd_data;
    logic   r_rd_vld;
    t_idx   rd_addr;
    logic   we;
    t_word  wdata;
    t_word  leaf_word;

    // acceptance
    logic   accept;
    logic [IN_POS_W-1:0] acc_clamp;
    logic [IN_POS_W-1:0] acc_sub;
    logic [POS_W-1:0]    acc_key;
    logic   acc_skip;

    t_scan_req scan_req;
    t_scan_rsp scan_rsp;
    t_scan_dir qdir;

    hbs_scan u_scan (
        .i_clk (i_clk),
        .i_req (scan_req),
        .o_rsp (scan_rsp)
    );

    assign o_stall           = (r_state != ST_IDLE);
    assign accept            = i_valid && (r_state == ST_IDLE);
    assign o_valid           = r_o_valid;
    assign o_found           = r_o_found;
    assign o_result_position = r_o_pos;
    assign leaf_word         = r_rd_vld ? r_rd_data : '0;
    assign qdir              = (r_op == OP_PRED) ? SCAN_HIGH : SCAN_LOW;

    // predecessor searches from position-1, clamped to the capacity
    always_comb begin
        acc_clamp = (i_position > IN_POS_W'(CAPACITY)) ? IN_POS_W'(CAPACITY) : i_position;
        acc_sub   = acc_clamp - IN_POS_W'(1);
        if (i_operation == OP_PRED) begin
            acc_key  = acc_sub[POS_W-1:0];
            acc_skip = (i_position == '0);
        end else begin
            acc_key  = i_position[POS_W-1:0];
            acc_skip = i_position[IN_POS_W-1];
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_widx      = r_widx;
        n_bpos      = r_bpos;
        n_skip      = r_skip;
        n_res_found = r_res_found;
        n_res_pos   = r_res_pos;
        n_summary   = r_summary;
        n_o_valid   = r_o_valid && i_stall;
        n_o_found   = r_o_found;
        n_o_pos     = r_o_pos;
        rd_addr     = r_widx;
        we          = 1'b0;
        wdata       = leaf_word;
        scan_req.word  = leaf_word;
        scan_req.bound = r_bpos;
        scan_req.dir   = qdir;

        case (r_state)
            ST_IDLE: begin
                rd_addr = acc_key[POS_W-1:IDX_W];
                if (accept) begin
                    n_op        = i_operation;
                    n_widx      = acc_key[POS_W-1:IDX_W];
                    n_bpos      = acc_key[IDX_W-1:0];
                    n_skip      = acc_skip;
                    n_res_found = 1'b0;
                    n_res_pos   = '0;
                    n_state     = ST_LEAF;
                end
            end
            ST_LEAF: begin
                n_state = ST_DONE;
                case (r_op)
                    OP_TEST: begin
                        n_res_found = !r_skip && leaf_word[r_bpos];
                    end
                    OP_INSERT: begin
                        if (!r_skip) begin
                            we        = 1'b1;
                            wdata     = leaf_word | (t_word'(1) << r_bpos);
                            n_summary = r_summary | (t_word'(1) << r_widx);
                        end
                    end
                    OP_REMOVE: begin
                        if (!r_skip) begin
                            we    = 1'b1;
                            wdata = leaf_word & ~(t_word'(1) << r_bpos);
                            if (wdata == '0) begin
                                n_summary = r_summary & ~(t_word'(1) << r_widx);
                            end
                        end
                    end
                    OP_SUCC, OP_PRED: begin
                        if (!r_skip) begin
                            n_state = ST_SCAN_LEAF;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_SCAN_LEAF: begin
                // hit in the first leaf word, else done if no word is left, else search the summary
                scan_req.word = r_summary;
                if (qdir == SCAN_LOW) begin
                    scan_req.bound = r_widx + t_idx'(1);
                end else begin
                    scan_req.bound = r_widx - t_idx'(1);
                end
                if (scan_rsp.any_set) begin
                    n_res_found = 1'b1;
                    n_res_pos   = {r_widx, scan_rsp.idx};
                    n_state     = ST_DONE;
                end else if ((qdir == SCAN_LOW && r_widx == '1) ||
                             (qdir == SCAN_HIGH && r_widx == '0)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SCAN_SUM;
                end
            end
            ST_SCAN_SUM: begin
                rd_addr = scan_rsp.idx;
                if (scan_rsp.any_set) begin
                    n_widx  = scan_rsp.idx;
                    n_state = ST_LEAF2;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_LEAF2: begin
                // full-word scan of the leaf found through the summary
                scan_req.bound = (qdir == SCAN_LOW) ? '0 : '1;
                n_state        = ST_SCAN_DESC;
            end
            ST_SCAN_DESC: begin
                n_res_found = scan_rsp.any_set;
                n_res_pos   = scan_rsp.any_set ? {r_widx, scan_rsp.idx} : '0;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    n_o_found = r_res_found;
                    n_o_pos   = r_res_pos;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_summary <= '0;
            r_vld     <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_summary <= n_summary;
            if (we) begin
                r_vld[r_widx] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_widx      <= n_widx;
        r_bpos      <= n_bpos;
        r_skip      <= n_skip;
        r_res_found <= n_res_found;
        r_res_pos   <= n_res_pos;
        r_o_found   <= n_o_found;
        r_o_pos     <= n_o_pos;
    end

    // leaf memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_widx] <= wdata;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
    end

endmodule

`default_nettype wire
